### src/efr_pkg.sv
package efr_pkg;

  typedef enum logic [2:0] {
    REG_START, REG_ESCAPE, REG_ADDR, REG_EUI, REG_TIMEOUT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    KIND_HEADER, KIND_TYPE, KIND_SEQ, KIND_LENGTH, KIND_ADDRESS, KIND_PAYLOAD,
    KIND_GOOD, KIND_BAD_CRC, KIND_TIMEOUT
  } kind_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  address_flag_mask;
    logic [3:0]  eui64_type_code;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       tick;
    logic       escaped;
    logic [7:0] data;
  } token_t;

endpackage

### src/efr_if.sv
interface efr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface efr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  value;
  logic [7:0]  position;
  logic [15:0] computed_crc;
  logic        end_of_frame;

  modport source (output valid, output kind, output value, output position,
                  output computed_crc, output end_of_frame, input ready);
  modport sink (input valid, input kind, input value, input position,
                input computed_crc, input end_of_frame, output ready);
endinterface

interface efr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/efr_front.sv
module efr_front
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  efr_in_if.sink     in_if,
  input  cfg_t       cfg,
  input  logic       fifo_full,
  output logic       push,
  output token_t     tok
);

  logic        esc_pending_r, esc_pending_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        accept;
  logic [16:0] idle_inc;

  assign in_if.ready = !fifo_full;
  assign accept      = in_if.valid && !fifo_full;
  assign idle_inc    = {1'b0, idle_r} + 17'd1;

  always_comb begin
    esc_pending_nxt = esc_pending_r;
    idle_nxt        = idle_r;
    push            = 1'b0;
    tok.tick        = 1'b0;
    tok.escaped     = 1'b0;
    tok.data        = in_if.rx_byte;
    if (accept) begin
      if (in_if.opcode) begin
        if (idle_inc >= {1'b0, cfg.timeout_ticks}) begin
          idle_nxt        = '0;
          esc_pending_nxt = 1'b0;
          push            = 1'b1;
          tok.tick        = 1'b1;
          tok.data        = '0;
        end else begin
          idle_nxt = idle_inc[15:0];
        end
      end else begin
        idle_nxt = '0;
        if (esc_pending_r) begin
          esc_pending_nxt = 1'b0;
          push            = 1'b1;
          tok.escaped     = 1'b1;
          tok.data        = ~in_if.rx_byte;
        end else if (in_if.rx_byte == cfg.escape_byte) begin
          esc_pending_nxt = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pending_r <= 1'b0;
      idle_r        <= '0;
    end else begin
      esc_pending_r <= esc_pending_nxt;
      idle_r        <= idle_nxt;
    end
  end

endmodule

### src/efr_fifo.sv
module efr_fifo
  import efr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t wdata,
  output logic   full,
  input  logic   pop,
  output token_t rdata,
  output logic   not_empty
);

  token_t     mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rdata     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/efr_back.sv
module efr_back
  import efr_pkg::*;
#(
  parameter int EUI_ADDRESS_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       tok_valid,
  input  token_t     tok,
  output logic       pop,
  efr_out_if.source  out_if
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_TYPE, PH_SEQ, PH_LENGTH,
    PH_ADDRESS, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO
  } phase_t;

  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [7:0] EUI_LAST     = 8'(EUI_ADDRESS_BYTES);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [7:0]  length_r, length_nxt;
  logic        along_r, along_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [7:0]  value_r, value_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] ocrc_r, ocrc_nxt;
  logic        eof_r, eof_nxt;

  logic [15:0] crc_upd;
  logic        emit;
  logic        along_eff;
  logic [7:0]  count_inc;

  assign pop       = tok_valid && (!out_valid_r || out_if.ready);
  assign crc_upd   = crc_byte(crc_r, tok.data);
  assign along_eff = along_r || (count_r == 8'd0 && tok.data[3:0] == cfg.eui64_type_code);
  assign count_inc = count_r + 8'd1;

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = kind_r;
  assign out_if.value        = value_r;
  assign out_if.position     = pos_r;
  assign out_if.computed_crc = ocrc_r;
  assign out_if.end_of_frame = eof_r;

  always_comb begin
    phase_nxt    = phase_r;
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    header_nxt   = header_r;
    length_nxt   = length_r;
    along_nxt    = along_r;
    crc_nxt      = crc_r;
    crc_hi_nxt   = crc_hi_r;
    emit         = 1'b0;
    kind_nxt     = kind_r;
    value_nxt    = tok.data;
    pos_nxt      = '0;
    ocrc_nxt     = crc_upd;
    eof_nxt      = 1'b0;
    if (pop) begin
      if (tok.tick) begin
        emit         = 1'b1;
        kind_nxt     = KIND_TIMEOUT;
        value_nxt    = '0;
        ocrc_nxt     = crc_r;
        eof_nxt      = 1'b1;
        in_frame_nxt = 1'b0;
        phase_nxt    = PH_HEADER;
        count_nxt    = '0;
        crc_nxt      = '0;
        crc_hi_nxt   = '0;
      end else if (!in_frame_r) begin
        if (!tok.escaped && tok.data == cfg.start_byte) begin
          in_frame_nxt = 1'b1;
          phase_nxt    = PH_HEADER;
          count_nxt    = '0;
          crc_nxt      = '0;
          crc_hi_nxt   = '0;
        end
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            emit       = 1'b1;
            kind_nxt   = KIND_HEADER;
            header_nxt = tok.data;
            crc_nxt    = crc_upd;
            phase_nxt  = PH_TYPE;
          end
          PH_TYPE: begin
            emit      = 1'b1;
            kind_nxt  = KIND_TYPE;
            crc_nxt   = crc_upd;
            phase_nxt = PH_SEQ;
          end
          PH_SEQ: begin
            emit      = 1'b1;
            kind_nxt  = KIND_SEQ;
            crc_nxt   = crc_upd;
            phase_nxt = PH_LENGTH;
          end
          PH_LENGTH: begin
            emit       = 1'b1;
            kind_nxt   = KIND_LENGTH;
            crc_nxt    = crc_upd;
            length_nxt = tok.data;
            along_nxt  = 1'b0;
            count_nxt  = '0;
            if ((header_r & cfg.address_flag_mask) == cfg.address_flag_mask) begin
              phase_nxt = PH_ADDRESS;
            end else begin
              phase_nxt = (tok.data != 8'd0) ? PH_PAYLOAD : PH_CRC_HI;
            end
          end
          PH_ADDRESS: begin
            emit      = 1'b1;
            kind_nxt  = KIND_ADDRESS;
            pos_nxt   = count_r;
            crc_nxt   = crc_upd;
            along_nxt = along_eff;
            if (count_r >= (along_eff ? EUI_LAST : 8'd0)) begin
              count_nxt = '0;
              phase_nxt = (length_r != 8'd0) ? PH_PAYLOAD : PH_CRC_HI;
            end else begin
              count_nxt = count_inc;
            end
          end
          PH_PAYLOAD: begin
            emit      = 1'b1;
            kind_nxt  = KIND_PAYLOAD;
            pos_nxt   = count_r;
            crc_nxt   = crc_upd;
            count_nxt = count_inc;
            if (count_inc >= length_r) begin
              phase_nxt = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            crc_hi_nxt = tok.data;
            phase_nxt  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            emit         = 1'b1;
            kind_nxt     = ({crc_hi_r, tok.data} == crc_r) ? KIND_GOOD : KIND_BAD_CRC;
            value_nxt    = '0;
            ocrc_nxt     = crc_r;
            eof_nxt      = 1'b1;
            in_frame_nxt = 1'b0;
            phase_nxt    = PH_HEADER;
            count_nxt    = '0;
            crc_nxt      = '0;
            crc_hi_nxt   = '0;
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      in_frame_r  <= 1'b0;
      count_r     <= '0;
      header_r    <= '0;
      length_r    <= '0;
      along_r     <= 1'b0;
      crc_r       <= '0;
      crc_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      in_frame_r  <= in_frame_nxt;
      count_r     <= count_nxt;
      header_r    <= header_nxt;
      length_r    <= length_nxt;
      along_r     <= along_nxt;
      crc_r       <= crc_nxt;
      crc_hi_r    <= crc_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      pos_r   <= pos_nxt;
      ocrc_r  <= ocrc_nxt;
      eof_r   <= eof_nxt;
    end
  end

endmodule

### src/escaped_frame_receiver.sv
// Channel   Dir  Payload                                          Transfer when
// in_if     in   opcode[0], rx_byte[7:0]                          valid && ready
// out_if    out  kind[3:0], value, position, computed_crc[15:0],   valid && ready
//                end_of_frame
// cfg_if    in   index[2:0], data[15:0]                           valid && ready
//
// One item per cycle while out_if is free; queue and output are registered.
// The front decodes escapes and counts idle ticks, a two-entry queue feeds the
// back, which parses fields and runs the CRC one byte per cycle.
// Synchronous active-low reset; no memory clearing pass. in_if stalls only when
// the queue is full; the queue fills when out_if is held off.
module escaped_frame_receiver
  import efr_pkg::*;
#(
  parameter int EUI_ADDRESS_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  efr_in_if.sink    in_if,
  efr_out_if.source out_if,
  efr_cfg_if.sink   cfg_if
);

  cfg_t   cfg_r;
  logic   push;
  logic   pop;
  logic   full;
  logic   not_empty;
  token_t tok_in;
  token_t tok_out;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte        <= 8'h7e;
      cfg_r.escape_byte       <= 8'h7d;
      cfg_r.address_flag_mask <= 8'h40;
      cfg_r.eui64_type_code   <= 4'd2;
      cfg_r.timeout_ticks     <= 16'd1000;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_START:   cfg_r.start_byte        <= cfg_if.data[7:0];
        REG_ESCAPE:  cfg_r.escape_byte       <= cfg_if.data[7:0];
        REG_ADDR:    cfg_r.address_flag_mask <= cfg_if.data[7:0];
        REG_EUI:     cfg_r.eui64_type_code   <= cfg_if.data[3:0];
        REG_TIMEOUT: cfg_r.timeout_ticks     <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  efr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg       (cfg_r),
    .fifo_full (full),
    .push      (push),
    .tok       (tok_in)
  );

  efr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (tok_in),
    .full      (full),
    .pop       (pop),
    .rdata     (tok_out),
    .not_empty (not_empty)
  );

  efr_back #(
    .EUI_ADDRESS_BYTES (EUI_ADDRESS_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .tok_valid (not_empty),
    .tok       (tok_out),
    .pop       (pop),
    .out_if    (out_if)
  );

endmodule
